/* hw/rtl/kmde_pkg.sv */
// ============================================================================
// kmde_pkg: keypad matrix debounce events package
// Matrix geometry, event buffer depth, field widths and sequencer states.
// ============================================================================
package kmde_pkg;

    // Matrix geometry and event buffer depth.
    localparam int ROW_COUNT    = 6;
    localparam int COLUMN_COUNT = 4;
    localparam int EVENT_DEPTH  = 5;

    // Fixed field widths of the channels.
    localparam int LEVEL_W  = 24;
    localparam int POS_W    = 5;
    localparam int TOTAL_W  = 3;
    localparam int RESULT_SLOTS = 5;

    // Code that marks an empty event slot.
    localparam logic [POS_W-1:0] EMPTY_CODE = POS_W'(24);

    // Only keys covered by the sampled level bits can ever log a press.
    localparam int MATRIX_KEYS = ROW_COUNT * COLUMN_COUNT;
    localparam int KEY_COUNT   = (MATRIX_KEYS < LEVEL_W) ? MATRIX_KEYS : LEVEL_W;

    // Internal widths.
    localparam int IDX_W  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int CNT_W  = $clog2(EVENT_DEPTH + 1);
    localparam int SLOT_W = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;

    // Item kinds on the request channel.
    localparam logic KIND_SCAN = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Sequencer states.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } seq_state_t;

endpackage

/* hw/rtl/kmde_req_if.sv */
// ============================================================================
// kmde_req_if: request channel
// Carries scan snapshots and read requests with a valid/ready handshake.
// ============================================================================
interface kmde_req_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [kmde_pkg::LEVEL_W-1:0]        key_levels;

    modport source (output valid, output kind, output key_levels, input ready);
    modport sink   (input valid, input kind, input key_levels, output ready);
endinterface

/* hw/rtl/kmde_rsp_if.sv */
// ============================================================================
// kmde_rsp_if: response channel
// Carries the event buffer contents and count with a valid/ready handshake.
// ============================================================================
interface kmde_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [kmde_pkg::POS_W-1:0]          slot_zero;
    logic [kmde_pkg::POS_W-1:0]          slot_one;
    logic [kmde_pkg::POS_W-1:0]          slot_two;
    logic [kmde_pkg::POS_W-1:0]          slot_three;
    logic [kmde_pkg::POS_W-1:0]          slot_four;
    logic [kmde_pkg::TOTAL_W-1:0]        event_total;

    modport source (output valid, output slot_zero, output slot_one, output slot_two,
                    output slot_three, output slot_four, output event_total,
                    input ready);
    modport sink   (input valid, input slot_zero, input slot_one, input slot_two,
                    input slot_three, input slot_four, input event_total,
                    output ready);
endinterface

/* hw/rtl/keypad_matrix_debounce_events_core.sv */
// ============================================================================
// keypad_matrix_debounce_events_core: keypad debounce and press-event logger
// A scan item is accepted and then walks KEY_COUNT keys (24 here), one a cycle,
// and no new item is taken until the walk is done. A read item puts its result
// in the output register in the cycle after it is accepted. No item is accepted
// while a result waits in the output register, unless it is drained that cycle.
// Reset (asynchronous, active low) clears scan history and count and fills
// every event slot with the empty code.
// ============================================================================
module keypad_matrix_debounce_events_core (
    input  logic              clk,
    input  logic              rst_n,
    kmde_req_if.sink          req,
    kmde_rsp_if.source        rsp
);

    // A key is held when it is high in this scan and the previous one. A new
    // press is a key held now that was not held on the previous scan. On a
    // scan item the scan history is updated at once and the new-press vector
    // is captured in a shift register. The sequencer then walks the keys in
    // row-major order, one per cycle: the lowest bit of the shift register
    // is tested, and a press is logged at the current count while the
    // buffer has room. The block accepts no item during the walk.
    //
    // A read item copies the five slots and the count into the output
    // register and clears the count. Slot contents are left as they are, so
    // stale positions stay readable. Slots that do not exist in a shallow
    // buffer read as the empty code.

    kmde_pkg::seq_state_t                 state_reg, state_next;
    logic [kmde_pkg::LEVEL_W-1:0]         prev_reg, prev_next;
    logic [kmde_pkg::KEY_COUNT-1:0]       held_reg, held_next;
    logic [kmde_pkg::KEY_COUNT-1:0]       press_reg, press_next;
    logic [kmde_pkg::IDX_W-1:0]           idx_reg, idx_next;
    logic [kmde_pkg::CNT_W-1:0]           count_reg, count_next;
    logic [kmde_pkg::POS_W-1:0]           slots_reg [kmde_pkg::EVENT_DEPTH];
    logic [kmde_pkg::POS_W-1:0]           slots_next [kmde_pkg::EVENT_DEPTH];
    logic                                 out_valid_reg, out_valid_next;
    logic [kmde_pkg::POS_W-1:0]           out_slots_reg [kmde_pkg::RESULT_SLOTS];
    logic [kmde_pkg::POS_W-1:0]           out_slots_next [kmde_pkg::RESULT_SLOTS];
    logic [kmde_pkg::TOTAL_W-1:0]         out_total_reg, out_total_next;

    logic                                 in_accept;
    logic [kmde_pkg::KEY_COUNT-1:0]       held_now;
    logic                                 room;

    // The output register can take a new result when it is empty or being
    // drained in this cycle.
    assign req.ready = (state_reg == kmde_pkg::ST_IDLE)
                       && (!out_valid_reg || rsp.ready);
    assign in_accept = req.valid && req.ready;

    assign held_now = req.key_levels[kmde_pkg::KEY_COUNT-1:0]
                      & prev_reg[kmde_pkg::KEY_COUNT-1:0];
    assign room     = (count_reg < kmde_pkg::CNT_W'(kmde_pkg::EVENT_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        held_next      = held_reg;
        press_next     = press_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        slots_next     = slots_reg;
        out_valid_next = out_valid_reg;
        out_slots_next = out_slots_reg;
        out_total_next = out_total_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            kmde_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (req.kind == kmde_pkg::KIND_SCAN)
                    begin
                        press_next = held_now & ~held_reg;
                        held_next  = held_now;
                        prev_next  = req.key_levels;
                        idx_next   = '0;
                        state_next = kmde_pkg::ST_WALK;
                    end
                    else
                    begin
                        for (int k = 0; k < kmde_pkg::RESULT_SLOTS; k++)
                        begin
                            if (k < kmde_pkg::EVENT_DEPTH)
                            begin
                                out_slots_next[k] = slots_reg[k];
                            end
                            else
                            begin
                                out_slots_next[k] = kmde_pkg::EMPTY_CODE;
                            end
                        end
                        out_total_next = kmde_pkg::TOTAL_W'(count_reg);
                        out_valid_next = 1'b1;
                        count_next     = '0;
                    end
                end
            end
            kmde_pkg::ST_WALK:
            begin
                if (press_reg[0] && room)
                begin
                    slots_next[count_reg[kmde_pkg::SLOT_W-1:0]] =
                        kmde_pkg::POS_W'(idx_reg);
                    count_next = count_reg + 1'b1;
                end
                press_next = press_reg >> 1;
                idx_next   = idx_reg + 1'b1;
                if (idx_reg == kmde_pkg::IDX_W'(kmde_pkg::KEY_COUNT - 1))
                begin
                    state_next = kmde_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kmde_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kmde_pkg::ST_IDLE;
            prev_reg      <= '0;
            held_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < kmde_pkg::EVENT_DEPTH; i++)
            begin
                slots_reg[i] <= kmde_pkg::EMPTY_CODE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            held_reg      <= held_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            slots_reg     <= slots_next;
        end
    end

    // Working and result data registers need no reset.
    always_ff @(posedge clk)
    begin
        press_reg     <= press_next;
        idx_reg       <= idx_next;
        out_slots_reg <= out_slots_next;
        out_total_reg <= out_total_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.slot_zero   = out_slots_reg[0];
    assign rsp.slot_one    = out_slots_reg[1];
    assign rsp.slot_two    = out_slots_reg[2];
    assign rsp.slot_three  = out_slots_reg[3];
    assign rsp.slot_four   = out_slots_reg[4];
    assign rsp.event_total = out_total_reg;

endmodule
